>>> design/rwsd_pkg.sv
`default_nettype none
package rwsd_pkg;
  localparam int WINDOW_MAX_DEF    = 256;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int SAMPLE_W          = 18;
  localparam int CFG_W             = 9;
  localparam int WIN_RESET         = 20;
endpackage
`default_nettype wire

>>> design/rwsd_line_mem.sv
`default_nettype none
module rwsd_line_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 18
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);
  logic [DW-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

>>> design/rwsd_divider.sv
`default_nettype none
module rwsd_divider #(
  parameter int NW = 96,
  parameter int DW = 24,
  parameter int QW = 48
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic               done,
  output logic      [QW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] n;
  logic [DW:0]   rem;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   shifted;

  // restoring division, one numerator bit per cycle
  always_comb begin
    shifted = {rem[DW-1:0], n[NW-1]};
    trial   = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n    <= num;
        rem  <= '0;
        cnt  <= CW'(NW);
        quo  <= '0;
      end else if (busy) begin
        n <= {n[NW-2:0], 1'b0};
        if (!trial[DW]) begin
          rem <= trial;
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[QW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> design/rwsd_sqrt.sv
`default_nettype none
module rwsd_sqrt #(
  parameter int VW = 48,
  parameter int RW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [VW-1:0] val,
  output logic               done,
  output logic      [RW-1:0] root
);
  localparam int CW = $clog2(RW + 1);
  logic [VW-1:0] v;
  logic [RW+1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [RW+1:0] sh;
  logic [RW+1:0] tr;

  // digit-by-digit root, two radicand bits per cycle
  always_comb begin
    sh = {rem[RW-1:0], v[VW-1:VW-2]};
    tr = sh - {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        v    <= val;
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(RW);
      end else if (busy) begin
        v <= {v[VW-3:0], 2'b00};
        if (!tr[RW+1]) begin
          rem  <= tr;
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem  <= sh;
          root <= {root[RW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> design/rolling_window_std_dev_unit.sv
// Channel | Dir | Payload
// s_axis  | in  | tdata[17:0] gross_return, tuser[0] start_series
// m_axis  | out | tdata[17:0] volatility
// cfg     | in  | cfg_data[8:0] window_length
// One item at a time. From accept to result: read the oldest entry, update the
// sums, multiply, divide (one bit per cycle), take the root (two bits per cycle)
// and load the result; divide and root are skipped when the count is below two
// or the variance is zero. The next item is taken once the unit is back in idle.
// Reset is synchronous: window 20, sums and counts zero; no memory clearing.
// A stalled result holds; the next item is taken and runs until its result is due.
`default_nettype none
module rolling_window_std_dev_unit #(
  parameter int WINDOW_MAX    = rwsd_pkg::WINDOW_MAX_DEF,
  parameter int FRACTION_BITS = rwsd_pkg::FRACTION_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [17:0] gross_return
  input  wire logic [0:0]  s_axis_tuser,  // [0] start_series
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,  // [17:0] volatility
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data       // [8:0] window_length
);
  import rwsd_pkg::*;

  localparam int AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNW = $clog2(WINDOW_MAX + 1);
  localparam int MW  = (FRACTION_BITS >= SAMPLE_W) ? FRACTION_BITS + 1 : SAMPLE_W;
  localparam int DV  = MW + 1;                 // signed deviation
  localparam int SW  = DV + CNW;               // sum
  localparam int QW  = 2 * MW + CNW;           // square sum
  localparam int AW2 = QW + CNW;               // cnt*Q
  localparam int NW  = AW2;                    // numerator
  localparam int DNW = 2 * CNW;                // cnt*(cnt-1)
  localparam int VW  = (NW % 2 == 0) ? NW : NW + 1;
  localparam int RW  = VW / 2;
  localparam logic [DV-1:0] ONE = DV'(1) << FRACTION_BITS;
  localparam logic [SAMPLE_W-1:0] VOL_MAX = '1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_READ = 8'b00000010, S_UPD = 8'b00000100,
    S_MUL1 = 8'b00001000, S_MUL2 = 8'b00010000, S_DIV = 8'b00100000,
    S_SQRT = 8'b01000000, S_OUT = 8'b10000000
  } state_t;

  state_t state;
  logic [CFG_W-1:0] win_len;
  logic [CNW-1:0]   w_eff, seen, cnt;
  logic [AW-1:0]    slot;
  logic signed [SW-1:0] sum;
  logic [QW-1:0]    sqs;
  logic [SAMPLE_W-1:0] sample;
  logic             full;
  logic [SAMPLE_W-1:0] old_raw;
  logic [SW-1:0]    sum_mag;
  logic [AW2-1:0]   prod_a;
  logic [2*SW-1:0]  prod_b;
  logic [DNW-1:0]   den;
  logic [NW-1:0]    num;
  logic             div_start, div_busy, div_done, sq_start, sq_done;
  logic [VW-1:0]    quo;
  logic [RW-1:0]    root;
  logic signed [DV-1:0] d_new, d_old;
  logic [MW-1:0]    m_new, m_old;
  logic [AW-1:0]    rd_addr;
  logic             out_load;

  // effective window: zero -> 1, saturate at WINDOW_MAX
  always_comb begin
    if (win_len == '0) w_eff = CNW'(1);
    else if (32'(win_len) > WINDOW_MAX) w_eff = CNW'(WINDOW_MAX);
    else w_eff = CNW'(win_len);
  end

  // oldest entry of the window, wrapping at WINDOW_MAX
  assign rd_addr = (32'(slot) >= 32'(w_eff)) ? AW'(32'(slot) - 32'(w_eff))
                                             : AW'(32'(slot) + WINDOW_MAX - 32'(w_eff));

  rwsd_line_mem #(.DEPTH(WINDOW_MAX), .AW(AW), .DW(SAMPLE_W)) u_mem (
    .clk(clk), .wr_en(state == S_UPD), .wr_addr(slot), .wr_data(sample),
    .rd_en(state == S_READ), .rd_addr(rd_addr), .rd_data(old_raw)
  );

  // deviations and magnitudes
  always_comb begin
    d_new = $signed(DV'(sample)) - $signed(ONE);
    d_old = $signed(DV'(old_raw)) - $signed(ONE);
    m_new = d_new[DV-1] ? MW'(-d_new) : MW'(d_new);
    m_old = d_old[DV-1] ? MW'(-d_old) : MW'(d_old);
  end

  assign sum_mag = sum[SW-1] ? SW'(-sum) : SW'(sum);

  assign s_axis_tready = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready     = (state == S_IDLE) && !m_axis_tvalid;
  assign num       = (prod_a > AW2'(prod_b)) ? NW'(prod_a - AW2'(prod_b)) : '0;
  assign div_start = (state == S_MUL2) && (cnt > CNW'(1)) && (prod_a > AW2'(prod_b));
  assign out_load  = ((state == S_OUT) || ((state == S_MUL2) && !div_start)) &&
                     (!m_axis_tvalid || m_axis_tready);

  rwsd_divider #(.NW(NW), .DW(DNW), .QW(VW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(den),
    .busy(div_busy), .done(div_done), .quo(quo)
  );

  assign sq_start = div_done;
  rwsd_sqrt #(.VW(VW), .RW(RW)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .val(quo), .done(sq_done), .root(root)
  );

  // sequencer: read old entry, update sums, multiply, divide, root, output
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      win_len       <= CFG_W'(WIN_RESET);
      seen          <= '0;
      slot          <= '0;
      sum           <= '0;
      sqs           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !out_load) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            win_len <= cfg_data[CFG_W-1:0];
            seen <= '0; slot <= '0; sum <= '0; sqs <= '0;
          end else if (s_axis_tvalid && s_axis_tready) begin
            sample <= s_axis_tdata[SAMPLE_W-1:0];
            if (s_axis_tuser[0]) begin
              seen <= '0; slot <= '0; sum <= '0; sqs <= '0;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          full  <= (seen >= w_eff);
          state <= S_UPD;
        end
        S_UPD: begin
          if (full) begin
            sum  <= sum - SW'(d_old) + SW'(d_new);
            sqs  <= sqs - QW'(m_old * m_old) + QW'(m_new * m_new);
            seen <= w_eff;
            cnt  <= w_eff;
          end else begin
            sum  <= sum + SW'(d_new);
            sqs  <= sqs + QW'(m_new * m_new);
            seen <= seen + 1'b1;
            cnt  <= seen + 1'b1;
          end
          slot  <= (32'(slot) == WINDOW_MAX - 1) ? '0 : AW'(32'(slot) + 1);
          state <= S_MUL1;
        end
        S_MUL1: begin
          den     <= DNW'(cnt) * DNW'(cnt - 1'b1);
          prod_a  <= AW2'(cnt) * AW2'(sqs);
          prod_b  <= sum_mag * sum_mag;
          state   <= S_MUL2;
        end
        S_MUL2: begin
          if (div_start) begin
            state <= S_DIV;
          end else if (out_load) begin
            m_axis_tdata  <= '0;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_DIV:  if (div_done) state <= S_SQRT;
        S_SQRT: if (sq_done)  state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            m_axis_tdata  <= 24'((root > RW'(VOL_MAX)) ? VOL_MAX : SAMPLE_W'(root));
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) div_done |-> state == S_DIV)
    else $error("divider finished outside divide state");
  assert property (@(posedge clk) disable iff (rst) div_busy |-> state == S_DIV)
    else $error("divider busy outside divide state");
  assert property (@(posedge clk) disable iff (rst) sq_done |-> state == S_SQRT)
    else $error("root finished outside root state");
  assert property (@(posedge clk) disable iff (rst) seen <= CNW'(WINDOW_MAX))
    else $error("sample count past window");
endmodule
`default_nettype wire

>>> verif/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rwsd_pkg::*;

  localparam int ONE = 1 << FRACTION_BITS_DEF;

  // Expected volatility per item, plus the running window state
  class vol_scoreboard;
    bit [8:0]  win_len;
    bit [17:0] samples[WINDOW_MAX_DEF];
    longint    run_sum;
    longint    run_sq;
    int        count;
    int        slot;
    bit [17:0] pending[$];
    int        errors;

    function new();
      win_len = 9'(WIN_RESET);
      clear_series();
    endfunction

    function void clear_series();
      run_sum = 0;
      run_sq = 0;
      count = 0;
      slot = 0;
    endfunction

    function void set_window(bit [8:0] w);
      win_len = w;
      clear_series();
    endfunction

    function bit [63:0] root_floor(bit [63:0] v);
      bit [63:0] r;
      r = 0;
      for (int b = 31; b >= 0; b--)
        if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r |= 64'd1 << b;
      return r;
    endfunction

    // note one accepted sample and queue its volatility
    function void note_sample(bit [17:0] g, bit first);
      int w;
      longint dv, od;
      bit [127:0] a, b, nume;
      bit [63:0] variance, vol;
      w = (win_len == 0) ? 1 : (win_len > WINDOW_MAX_DEF ? WINDOW_MAX_DEF : win_len);
      if (first) clear_series();
      if (count >= w) begin
        od = longint'(samples[(slot + WINDOW_MAX_DEF - w) % WINDOW_MAX_DEF]) - ONE;
        run_sum -= od;
        run_sq -= od * od;
        count = w;
      end else begin
        count++;
      end
      dv = longint'(g) - ONE;
      run_sum += dv;
      run_sq += dv * dv;
      samples[slot] = g;
      slot = (slot + 1) % WINDOW_MAX_DEF;
      vol = 0;
      if (count > 1) begin
        a = 128'(count) * 128'(run_sq);
        b = 128'(run_sum < 0 ? -run_sum : run_sum);
        b = b * b;
        if (a > b) begin
          nume = a - b;
          variance = 64'(nume / 128'(count * (count - 1)));
          vol = root_floor(variance);
          if (vol > 262143) vol = 262143;
        end
      end
      pending = {pending, vol[17:0]};
    endfunction

    function void check_result(bit [17:0] got);
      bit [17:0] want;
      if (pending.size() == 0) begin
        $error("volatility: unexpected result %0d", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("volatility: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = 0;
  logic [0:0]  s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 0;

  vol_scoreboard sb = new();
  bit sink_hold = 0;

  rolling_window_std_dev_unit dut (.*);

  always #10 clk = ~clk;

  // valid stays up after an item when the next follows with no gap
  task automatic send_sample(bit [17:0] g, bit first);
    int idle;
    idle = $urandom_range(0, 7);
    if (idle != 0) begin
      s_axis_tvalid <= 0;
      repeat (idle) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'd0, g};
    s_axis_tuser <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_sample(g, first);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_window(bit [8:0] w);
    drain();
    cfg_valid <= 1;
    cfg_data <= {7'd0, w};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_window(w);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic bit [17:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 18'($urandom_range(0, 262143));
      1: return 18'd0;
      2: return 18'd262143;
      default: return 18'(ONE - 2000 + $urandom_range(0, 4000));
    endcase
  endfunction

  // result side: random stalls, long hold when asked
  initial begin
    int idle;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (sink_hold) begin
        m_axis_tready <= 0;
        repeat (600) @(negedge clk);
        sink_hold = 0;
      end
      idle = $urandom_range(0, 7);
      if (idle != 0) begin
        m_axis_tready <= 0;
        repeat (idle) @(negedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_result(m_axis_tdata[17:0]);
      @(negedge clk);
    end
  end

  initial begin
    bit [8:0] windows[6] = '{9'd0, 9'd1, 9'd2, 9'd5, 9'd256, 9'd511};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: default window, extremes, constant series, new-series flag
    send_sample(18'd0, 0);
    send_sample(18'd262143, 0);
    send_sample(18'd65536, 0);
    send_sample(18'd65536, 1);
    send_sample(18'd65536, 0);
    send_sample(18'd1, 0);
    send_sample(18'd131072, 0);
    for (int i = 0; i < 16; i++) send_sample(i[0] ? 18'd262143 : 18'd0, 0);
    // receiver holds off while samples keep coming
    sink_hold = 1;
    for (int i = 0; i < 10; i++) send_sample(rand_sample(), 0);
    // sender pauses for all results
    drain();
    for (int p = 0; p < 6; p++) begin
      write_window(windows[p]);
      for (int i = 0; i < 20; i++) send_sample(rand_sample(), $urandom_range(0, 19) == 0);
    end
    // full window of 256 with wraparound, then a new series
    write_window(9'd256);
    for (int i = 0; i < 280; i++) send_sample(rand_sample(), i == 270);
    write_window(9'($urandom_range(3, 40)));
    for (int i = 0; i < 20; i++) send_sample(rand_sample(), $urandom_range(0, 9) == 0);
    drain();
    if (sb.errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #100ms;
    $display("testbench: errors");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
design/rwsd_pkg.sv
design/rwsd_line_mem.sv
design/rwsd_divider.sv
design/rwsd_sqrt.sv
design/rolling_window_std_dev_unit.sv
verif/testbench.sv
